FILE: src/lcs_pkg.sv
// Shared constants, codes and types for the lever calibrate-and-scale block.
// No dependencies; used by lcs_div and lever_calibrate_and_scale.
package lcs_pkg;

  // Default converter width and fixed field widths
  localparam int ADC_BITS_DEF = 16;
  localparam int DZ_W         = 13;
  localparam int SPAN_W       = 16;
  localparam int POS_W        = 15;
  localparam int PHASE_W      = 3;
  localparam int ERR_W        = 2;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 16;

  // Shared divider geometry
  localparam int DIVIDEND_W = 32;
  localparam int DIVISOR_W  = 16;

  // Fixed-point constants
  localparam logic [DIVISOR_W-1:0]  FRAC_DEN   = 16'd10000;
  localparam logic [DIVIDEND_W-1:0] CEIL_BIAS  = 32'd9999;
  localparam logic [POS_W-1:0]      FULL_POS   = 15'd25600;
  localparam logic [DIVIDEND_W-1:0] SCALE_NUM  = 32'd1677721600; // 25600 << 16

  // Reciprocal of 10000: (x * FRAC_RECIP) >> FRAC_SHIFT is exact for x below 2^31
  localparam int                    FRAC_SHIFT = 44;
  localparam logic [DIVIDEND_W-1:0] FRAC_RECIP = 32'd1759218605;

  // Configuration reset values
  localparam logic [DZ_W-1:0]   LOW_DZ_RST   = 13'd225;
  localparam logic [DZ_W-1:0]   HIGH_DZ_RST  = 13'd175;
  localparam logic [DZ_W-1:0]   HYST_W_RST   = 13'd50;
  localparam logic [SPAN_W-1:0] MIN_SPAN_RST = 16'd25000;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_DZ   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_DZ  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HYST_W   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_SPAN = 2'd3;

  // Calibration phase codes
  localparam logic [PHASE_W-1:0] PH_WAIT_FWD = 3'd0;
  localparam logic [PHASE_W-1:0] PH_CAP_MAX  = 3'd1;
  localparam logic [PHASE_W-1:0] PH_WAIT_RST = 3'd2;
  localparam logic [PHASE_W-1:0] PH_CAP_MIN  = 3'd3;
  localparam logic [PHASE_W-1:0] PH_READY    = 3'd4;

  // Error codes
  localparam logic [ERR_W-1:0] ERR_NONE  = 2'd0;
  localparam logic [ERR_W-1:0] ERR_BOTH  = 2'd1;
  localparam logic [ERR_W-1:0] ERR_SPAN  = 2'd2;

  // Request into the shared divider
  typedef struct packed {
    logic                  start;
    logic [DIVIDEND_W-1:0] dividend;
    logic [DIVISOR_W-1:0]  divisor;
  } div_req_t;

endpackage

FILE: src/lcs_div.sv
// Shared restoring divider, one quotient bit per cycle.
// Depends on lcs_pkg (widths, div_req_t).
module lcs_div
  import lcs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  div_req_t              req,
  output logic                  done,
  output logic [DIVIDEND_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DIVIDEND_W);

  logic                  busy;
  logic [CNT_W-1:0]      cnt;
  logic [DIVISOR_W-1:0]  rem;
  logic [DIVISOR_W-1:0]  dsr;
  logic [DIVISOR_W:0]    trial;
  logic                  fits;

  // Shift in next dividend bit and test against divisor
  assign trial = {rem, quotient[DIVIDEND_W-1]};
  assign fits  = trial >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(DIVIDEND_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: remainder and quotient shift register
  always_ff @(posedge clk) begin
    if (req.start) begin
      quotient <= req.dividend;
      rem      <= '0;
      dsr      <= req.divisor;
    end else if (busy) begin
      if (fits) begin
        rem      <= DIVISOR_W'(trial - {1'b0, dsr});
        quotient <= {quotient[DIVIDEND_W-2:0], 1'b1};
      end else begin
        rem      <= trial[DIVISOR_W-1:0];
        quotient <= {quotient[DIVIDEND_W-2:0], 1'b0};
      end
    end
  end

endmodule

FILE: src/lever_calibrate_and_scale.sv
// Lever calibration and position scaling, top level.
// Depends on lcs_pkg and lcs_div.
//
// channel  direction  handshake            payload
// in       sink       in_valid/in_ready    adc_reading, fwd_switch_closed, rest_switch_closed
// out      source     out_valid/out_ready  position, calibrated, phase, error_code
// cfg      sink       cfg_write            cfg_index, cfg_data
//
// Closing calibration uses reciprocal multiplies for the dead zones and hysteresis
// and one 32-step divider pass for the scale; with no working span the divider pass
// and the hysteresis multiply are skipped.
// Synchronous reset returns to the wait-forward phase with extremes cleared.
// in_ready is high only while the sequencer is idle; a result waiting on
// out_ready holds the sequencer in its emit state.
module lever_calibrate_and_scale
  import lcs_pkg::*;
#(
  parameter int ADC_BITS = ADC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [15:0]           adc_reading,
  input  logic                  fwd_switch_closed,
  input  logic                  rest_switch_closed,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [POS_W-1:0]      position,
  output logic                  calibrated,
  output logic [PHASE_W-1:0]    phase,
  output logic [ERR_W-1:0]      error_code,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int MUL_W = 2 * DIVIDEND_W;

  typedef enum logic [13:0] {
    S_IDLE   = 14'b00000000000001,
    S_STEP   = 14'b00000000000010,
    S_CHK    = 14'b00000000000100,
    S_LO     = 14'b00000000001000,
    S_LO_W   = 14'b00000000010000,
    S_HI     = 14'b00000000100000,
    S_HI_W   = 14'b00000001000000,
    S_EFF    = 14'b00000010000000,
    S_SC_W   = 14'b00000100000000,
    S_HY     = 14'b00001000000000,
    S_HY_W   = 14'b00010000000000,
    S_PMUL   = 14'b00100000000000,
    S_PCLAMP = 14'b01000000000000,
    S_EMIT   = 14'b10000000000000
  } seq_t;

  seq_t st, st_next;

  // Configuration
  logic [DZ_W-1:0]   low_deadzone, high_deadzone, hysteresis_width;
  logic [SPAN_W-1:0] min_span;

  // Calibration and tracking state
  logic [PHASE_W-1:0]  phase_reg;
  logic [ADC_BITS-1:0] max_reading, min_reading, low_end, high_end;
  logic [31:0]         scale_factor;
  logic [ADC_BITS-1:0] hysteresis_step, held_reading;
  logic                held_valid, calibrated_flag;
  logic [POS_W-1:0]    position_reg;
  logic [ERR_W-1:0]    err_reg;

  // Latched input word
  logic [ADC_BITS-1:0] rdg;
  logic                fwd, rest;

  // Shared arithmetic
  logic [DIVIDEND_W-1:0] mul_a;
  logic [31:0]           mul_b;
  logic [MUL_W-1:0]      mul_p, prod;
  logic [ADC_BITS-1:0]   frac_q;
  div_req_t              div_req;
  logic                  div_done;
  logic [DIVIDEND_W-1:0] div_q;

  // Step and calibration helpers
  logic [PHASE_W-1:0]  ph_c;
  logic [ADC_BITS-1:0] mx_c, mn_c;
  logic [ERR_W-1:0]    err_c;
  logic                fin_c;
  logic [ADC_BITS-1:0] span;
  logic                span_bad;
  logic [ADC_BITS:0]   eff_s;
  logic                eff_pos;
  logic [ADC_BITS-1:0] diff;
  logic                hold_pos;
  logic [ADC_BITS+15:0] pos_raw;

  assign in_ready = (st == S_IDLE);

  lcs_div u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (div_req),
    .done     (div_done),
    .quotient (div_q)
  );

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      low_deadzone     <= LOW_DZ_RST;
      high_deadzone    <= HIGH_DZ_RST;
      hysteresis_width <= HYST_W_RST;
      min_span         <= MIN_SPAN_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_LOW_DZ:   low_deadzone     <= cfg_data[DZ_W-1:0];
        CFG_HIGH_DZ:  high_deadzone    <= cfg_data[DZ_W-1:0];
        CFG_HYST_W:   hysteresis_width <= cfg_data[DZ_W-1:0];
        CFG_MIN_SPAN: min_span         <= cfg_data;
        default:      ;
      endcase
    end
  end

  // Calibration phase walk for one word, with fall-through between phases
  always_comb begin
    ph_c  = (phase_reg > PH_READY) ? PH_WAIT_FWD : phase_reg;
    mx_c  = max_reading;
    mn_c  = min_reading;
    err_c = ERR_NONE;
    fin_c = 1'b0;
    if (ph_c == PH_WAIT_FWD) begin
      if (fwd && rest) begin
        mx_c  = '0;
        mn_c  = '1;
        err_c = ERR_BOTH;
      end else if (fwd) begin
        ph_c = PH_CAP_MAX;
      end
    end
    if (ph_c == PH_CAP_MAX) begin
      if (rdg > mx_c) mx_c = rdg;
      if (!fwd) ph_c = PH_WAIT_RST;
    end
    if (ph_c == PH_WAIT_RST && rest) ph_c = PH_CAP_MIN;
    if (ph_c == PH_CAP_MIN) begin
      if (rdg < mn_c) mn_c = rdg;
      if (!rest) fin_c = 1'b1;
    end
  end

  // Span, effective span, hysteresis distance
  assign span     = max_reading - min_reading;
  assign span_bad = (max_reading < min_reading) || (SPAN_W'(span) < min_span);
  assign eff_s    = {1'b0, high_end} - {1'b0, low_end};
  assign eff_pos  = !eff_s[ADC_BITS] && (eff_s != '0);
  assign diff     = (rdg > held_reading) ? rdg - held_reading : held_reading - rdg;
  assign hold_pos = held_valid && (diff <= hysteresis_step);
  assign pos_raw  = prod[ADC_BITS+31:16];
  // Quotient by 10000 of the registered product, through the reciprocal
  assign frac_q   = mul_p[FRAC_SHIFT +: ADC_BITS];

  // Shared multiplier operands and divider requests
  always_comb begin
    mul_a   = 32'(span);
    mul_b   = 32'(low_deadzone);
    div_req = '0;
    unique case (st)
      S_LO_W, S_HI_W, S_HY_W: begin
        mul_a = prod[DIVIDEND_W-1:0];
        mul_b = FRAC_RECIP;
      end
      S_HI: begin
        mul_b = 32'(high_deadzone);
      end
      S_EFF: begin
        div_req.start    = eff_pos;
        div_req.dividend = SCALE_NUM;
        div_req.divisor  = DIVISOR_W'(eff_s[ADC_BITS-1:0]);
      end
      S_HY: begin
        mul_a = 32'(eff_s[ADC_BITS-1:0]);
        mul_b = 32'(hysteresis_width);
      end
      S_PMUL: begin
        mul_a = 32'(rdg - low_end);
        mul_b = scale_factor;
      end
      default: ;
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Sequencer
  always_comb begin
    st_next = st;
    unique case (st)
      S_IDLE:   if (in_valid) st_next = S_STEP;
      S_STEP: begin
        if (phase_reg == PH_READY) begin
          if (hold_pos || rdg < low_end || rdg > high_end) st_next = S_EMIT;
          else st_next = S_PMUL;
        end else if (fin_c) begin
          st_next = S_CHK;
        end else begin
          st_next = S_EMIT;
        end
      end
      S_CHK:    st_next = span_bad ? S_EMIT : S_LO;
      S_LO:     st_next = S_LO_W;
      S_LO_W:   st_next = S_HI;
      S_HI:     st_next = S_HI_W;
      S_HI_W:   st_next = S_EFF;
      S_EFF:    st_next = eff_pos ? S_SC_W : S_EMIT;
      S_SC_W:   if (div_done) st_next = S_HY;
      S_HY:     st_next = S_HY_W;
      S_HY_W:   st_next = S_EMIT;
      S_PMUL:   st_next = S_PCLAMP;
      S_PCLAMP: st_next = S_EMIT;
      S_EMIT:   if (!out_valid || out_ready) st_next = S_IDLE;
      default:  st_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) st <= S_IDLE;
    else     st <= st_next;
  end

  // Input word latch and product register
  always_ff @(posedge clk) begin
    if (st == S_IDLE && in_valid) begin
      rdg  <= adc_reading[ADC_BITS-1:0];
      fwd  <= fwd_switch_closed;
      rest <= rest_switch_closed;
    end
    // Dead-zone products carry the ceiling bias; hysteresis and position do not
    if (st == S_LO || st == S_HI) prod <= mul_p + MUL_W'(CEIL_BIAS);
    else if (st == S_HY || st == S_PMUL) prod <= mul_p;
  end

  // Calibration and position state updates
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_reg       <= PH_WAIT_FWD;
      max_reading     <= '0;
      min_reading     <= '1;
      low_end         <= '0;
      high_end        <= '0;
      scale_factor    <= '0;
      hysteresis_step <= '0;
      held_reading    <= '0;
      held_valid      <= 1'b0;
      position_reg    <= '0;
      calibrated_flag <= 1'b0;
      err_reg         <= ERR_NONE;
    end else begin
      unique case (st)
        S_STEP: begin
          if (phase_reg == PH_READY) begin
            err_reg <= ERR_NONE;
            if (!hold_pos) begin
              held_reading    <= rdg;
              held_valid      <= 1'b1;
              calibrated_flag <= 1'b1;
              if (rdg < low_end)       position_reg <= '0;
              else if (rdg > high_end) position_reg <= FULL_POS;
            end
          end else begin
            phase_reg   <= ph_c;
            max_reading <= mx_c;
            min_reading <= mn_c;
            err_reg     <= err_c;
          end
        end
        S_CHK: begin
          if (span_bad) begin
            max_reading <= '0;
            min_reading <= '1;
            phase_reg   <= PH_WAIT_FWD;
            err_reg     <= ERR_SPAN;
          end
        end
        S_LO_W: low_end  <= min_reading + frac_q;
        S_HI_W: high_end <= max_reading - frac_q;
        S_EFF: begin
          if (!eff_pos) begin
            scale_factor    <= '0;
            hysteresis_step <= '0;
            phase_reg       <= PH_READY;
          end
        end
        S_SC_W: if (div_done) scale_factor <= div_q;
        S_HY_W: begin
          hysteresis_step <= frac_q;
          phase_reg       <= PH_READY;
        end
        S_PCLAMP: begin
          if (pos_raw > (ADC_BITS+16)'(FULL_POS)) position_reg <= FULL_POS;
          else                                    position_reg <= pos_raw[POS_W-1:0];
        end
        default: ;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (st == S_EMIT && (!out_valid || out_ready)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (st == S_EMIT && (!out_valid || out_ready)) begin
      position   <= position_reg;
      calibrated <= calibrated_flag;
      phase      <= phase_reg;
      error_code <= err_reg;
    end
  end

endmodule

FILE: dv/tb_lever_calibrate_and_scale.sv
// Self-checking bench for lever_calibrate_and_scale: a scoreboard class tracks the calibration
// and hysteresis behavior and checks every output word against its own prediction.
// Depends on lcs_pkg and the lever_calibrate_and_scale RTL.
module tb_lever_calibrate_and_scale;
  import lcs_pkg::*;

  localparam int SAMPLES        = 550;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int TAIL_CYCLES    = 200;

  // One output word as the block should present it
  typedef struct packed {
    logic [POS_W-1:0]   pos;
    logic               cal;
    logic [PHASE_W-1:0] ph;
    logic [ERR_W-1:0]   err;
  } lever_word_t;

  // Tracks calibration state and lever position, queues the words the block owes
  class lever_position_tracker;
    logic [DZ_W-1:0]    low_dz, high_dz, hyst_w;
    logic [SPAN_W-1:0]  min_span;
    logic [PHASE_W-1:0] ph;
    logic [15:0]        max_rd, min_rd, low_end, high_end, hyst_step, held_rd;
    logic [31:0]        scale;
    logic               held_ok, cal_flag;
    logic [POS_W-1:0]   pos;
    lever_word_t        pending[$];
    int n_fail, n_checked, n_both, n_span, n_attempts, n_ready;

    function new();
      low_dz   = LOW_DZ_RST;
      high_dz  = HIGH_DZ_RST;
      hyst_w   = HYST_W_RST;
      min_span = MIN_SPAN_RST;
      ph       = PH_WAIT_FWD;
      clear_extremes();
      low_end   = '0;
      high_end  = '0;
      scale     = '0;
      hyst_step = '0;
      held_rd   = '0;
      held_ok   = 1'b0;
      cal_flag  = 1'b0;
      pos       = '0;
    endfunction

    function void clear_extremes();
      max_rd = '0;
      min_rd = '1;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_LOW_DZ:   low_dz   = data[DZ_W-1:0];
        CFG_HIGH_DZ:  high_dz  = data[DZ_W-1:0];
        CFG_HYST_W:   hyst_w   = data[DZ_W-1:0];
        CFG_MIN_SPAN: min_span = data[SPAN_W-1:0];
        default: ;
      endcase
    endfunction

    // ceil(span * hundredths / 10000)
    function logic [15:0] dead_share(int span, logic [DZ_W-1:0] hundredths);
      logic [63:0] prod;
      prod = 64'(span) * 64'(hundredths);
      return 16'((prod + 64'(CEIL_BIAS)) / 64'(FRAC_DEN));
    endfunction

    // Span check, dead-zone ends, reciprocal scale and hysteresis step
    function logic [ERR_W-1:0] close_calibration();
      int span;
      int eff;
      logic [63:0] hprod;
      n_attempts++;
      span = int'(max_rd) - int'(min_rd);
      if (span < int'(min_span)) begin
        clear_extremes();
        ph = PH_WAIT_FWD;
        n_span++;
        return ERR_SPAN;
      end
      low_end  = min_rd + dead_share(span, low_dz);
      high_end = max_rd - dead_share(span, high_dz);
      eff = int'(high_end) - int'(low_end);
      if (eff > 0) begin
        scale     = SCALE_NUM / 32'(eff);
        hprod     = 64'(eff) * 64'(hyst_w);
        hyst_step = 16'(hprod / 64'(FRAC_DEN));
      end else begin
        scale     = '0;
        hyst_step = '0;
      end
      ph = PH_READY;
      return ERR_NONE;
    endfunction

    // Ready phase: hysteresis, dead-zone clamps, scaled position
    function void follow_lever(logic [15:0] rd);
      logic [15:0] diff;
      logic [63:0] prod;
      diff = (rd > held_rd) ? rd - held_rd : held_rd - rd;
      n_ready++;
      if (held_ok && diff <= hyst_step) return;
      held_rd = rd;
      held_ok = 1'b1;
      if (rd < low_end) begin
        pos = '0;
      end else if (rd > high_end) begin
        pos = FULL_POS;
      end else begin
        prod = (64'(rd - low_end) * 64'(scale)) >> 16;
        pos  = (prod > 64'(FULL_POS)) ? FULL_POS : POS_W'(prod);
      end
      cal_flag = 1'b1;
    endfunction

    // Called for every accepted input word
    function void note_sample(logic [15:0] rd, logic fwd_sw, logic rest_sw);
      lever_word_t w;
      logic [ERR_W-1:0] err;
      err = ERR_NONE;
      if (ph > PH_READY) ph = PH_WAIT_FWD;
      if (ph == PH_READY) begin
        follow_lever(rd);
      end else begin
        if (ph == PH_WAIT_FWD) begin
          if (fwd_sw && rest_sw) begin
            clear_extremes();
            err = ERR_BOTH;
            n_both++;
          end else if (fwd_sw) begin
            ph = PH_CAP_MAX;
          end
        end
        if (ph == PH_CAP_MAX) begin
          if (rd > max_rd) max_rd = rd;
          if (!fwd_sw) ph = PH_WAIT_RST;
        end
        if (ph == PH_WAIT_RST && rest_sw) ph = PH_CAP_MIN;
        if (ph == PH_CAP_MIN) begin
          if (rd < min_rd) min_rd = rd;
          if (!rest_sw) err = close_calibration();
        end
      end
      w.pos = pos;
      w.cal = cal_flag;
      w.ph  = ph;
      w.err = err;
      pending.push_back(w);
    endfunction

    // Called for every accepted output word
    function void check_word(logic [POS_W-1:0] got_pos, logic got_cal,
                             logic [PHASE_W-1:0] got_ph, logic [ERR_W-1:0] got_err);
      lever_word_t want;
      if (pending.size() == 0) begin
        $error("output word with nothing pending: position %0d phase %0d error_code %0d",
               got_pos, got_ph, got_err);
        n_fail++;
        return;
      end
      want = pending.pop_front();
      n_checked++;
      if (got_pos !== want.pos) begin
        $error("position: expected %0d, got %0d", want.pos, got_pos);
        n_fail++;
      end
      if (got_cal !== want.cal) begin
        $error("calibrated: expected %0d, got %0d", want.cal, got_cal);
        n_fail++;
      end
      if (got_ph !== want.ph) begin
        $error("phase: expected %0d, got %0d", want.ph, got_ph);
        n_fail++;
      end
      if (got_err !== want.err) begin
        $error("error_code: expected %0d, got %0d", want.err, got_err);
        n_fail++;
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [15:0]           adc_reading = '0;
  logic                  fwd_switch_closed = 1'b0;
  logic                  rest_switch_closed = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [POS_W-1:0]      position;
  logic                  calibrated;
  logic [PHASE_W-1:0]    phase;
  logic [ERR_W-1:0]      error_code;
  logic                  cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  lever_position_tracker tracker = new();
  int n_sent = 0;
  int idle_cycles = 0;
  bit steady = 1'b0;

  lever_calibrate_and_scale DUT (
    .clk                (clk),
    .rst                (rst),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .adc_reading        (adc_reading),
    .fwd_switch_closed  (fwd_switch_closed),
    .rest_switch_closed (rest_switch_closed),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .position           (position),
    .calibrated         (calibrated),
    .phase              (phase),
    .error_code         (error_code),
    .cfg_write          (cfg_write),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Drive one input word; valid stays up across back-to-back words
  task automatic send_sample(input logic [15:0] rd, input logic fwd_sw, input logic rest_sw);
    int gap;
    steady = ((n_sent / 40) % 5) == 4;
    gap = steady ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid           <= 1'b1;
    adc_reading        <= rd;
    fwd_switch_closed  <= fwd_sw;
    rest_switch_closed <= rest_sw;
    do @(posedge clk); while (in_ready !== 1'b1);
    tracker.note_sample(rd, fwd_sw, rest_sw);
    n_sent++;
  endtask

  // Hold off the sender until every owed word has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    while (tracker.pending.size() != 0) @(posedge clk);
  endtask

  // Write all four registers on consecutive edges; block must be idle
  task automatic write_settings(input logic [CFG_DATA_W-1:0] low_dz, high_dz, hyst_w, span_min);
    cfg_write <= 1'b1;
    cfg_index <= CFG_LOW_DZ;
    cfg_data  <= low_dz;
    @(posedge clk);
    cfg_index <= CFG_HIGH_DZ;
    cfg_data  <= high_dz;
    @(posedge clk);
    cfg_index <= CFG_HYST_W;
    cfg_data  <= hyst_w;
    @(posedge clk);
    cfg_index <= CFG_MIN_SPAN;
    cfg_data  <= span_min;
    @(posedge clk);
    cfg_write <= 1'b0;
    tracker.write_reg(CFG_LOW_DZ, low_dz);
    tracker.write_reg(CFG_HIGH_DZ, high_dz);
    tracker.write_reg(CFG_HYST_W, hyst_w);
    tracker.write_reg(CFG_MIN_SPAN, span_min);
  endtask

  function automatic logic [15:0] top_reading(bit good);
    return good ? 16'($urandom_range(45000, 65535)) : 16'($urandom);
  endfunction

  function automatic logic [15:0] bottom_reading(bit good);
    return good ? 16'($urandom_range(0, 20000)) : 16'($urandom);
  endfunction

  function automatic logic [15:0] reading_near(int base, int off);
    int v;
    v = base + off;
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return 16'(v);
  endfunction

  // One calibration pass: noise, forward capture, rest capture, release.
  // A good pass has a wide span; a bad one uses random readings.
  task automatic run_calibration(input bit good);
    bit rest_now;
    repeat ($urandom_range(0, 3)) begin
      rest_now = 1'($urandom_range(0, 1));
      send_sample(16'($urandom), rest_now && ($urandom_range(0, 5) == 0), rest_now);
    end
    send_sample(top_reading(good), 1'b1, 1'b0);
    repeat ($urandom_range(0, 5))
      send_sample(top_reading(good), 1'b1, 1'($urandom_range(0, 1)));
    rest_now = 1'($urandom_range(0, 1));
    send_sample(top_reading(good), 1'b0, rest_now);
    if (!rest_now) begin
      repeat ($urandom_range(0, 3))
        send_sample(16'($urandom), 1'($urandom_range(0, 1)), 1'b0);
      send_sample(bottom_reading(good), 1'($urandom_range(0, 1)), 1'b1);
    end
    repeat ($urandom_range(0, 5))
      send_sample(bottom_reading(good), 1'($urandom_range(0, 1)), 1'b1);
    send_sample(bottom_reading(good), 1'($urandom_range(0, 1)), 1'b0);
  endtask

  // Output side: random stalls, accept when out_valid is seen with ready up
  initial begin
    int stall;
    forever begin
      stall = steady ? 0 : $urandom_range(0, 6);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (rst || out_valid !== 1'b1);
    end
  end

  // Check every accepted output word
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      tracker.check_word(position, calibrated, phase, error_code);
  end

  // Watchdog on cycles with no handshake
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || cfg_write) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no word moved for %0d cycles, %0d words still owed",
                 idle_cycles, tracker.pending.size());
        $display("tb_lever_calibrate_and_scale failed");
        $finish;
      end
    end
  end

  // Stimulus
  initial begin
    int kind;
    int off;
    logic [15:0] rd;
    logic [CFG_DATA_W-1:0] low_dz, high_dz, hyst_w, span_min;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Default settings: idle, rest alone, both closed, then a span that is too small
    send_sample(16'd5000, 1'b0, 1'b0);
    send_sample(16'd0, 1'b0, 1'b1);
    send_sample(16'hFFFF, 1'b1, 1'b1);
    send_sample(16'd1000, 1'b1, 1'b0);
    send_sample(16'd2000, 1'b1, 1'b1);
    send_sample(16'd9999, 1'b0, 1'b0);
    send_sample(16'd300, 1'b1, 1'b0);
    send_sample(16'd1500, 1'b0, 1'b1);
    send_sample(16'd1200, 1'b1, 1'b1);
    send_sample(16'd1300, 1'b0, 1'b0);
    drain_results();

    // Widest dead zones and hysteresis, no span floor; max ends below min
    write_settings(16'd5000, 16'd5000, 16'd5000, 16'd0);
    send_sample(16'd100, 1'b1, 1'b0);
    send_sample(16'd50, 1'b0, 1'b0);
    send_sample(16'd200, 1'b0, 1'b1);
    send_sample(16'd300, 1'b0, 1'b0);
    drain_results();

    // Zero dead zones, highest span floor; a span one short of it
    write_settings(16'd0, 16'd0, 16'd0, 16'hFFFF);
    send_sample(16'hFFFF, 1'b1, 1'b0);
    send_sample(16'd1, 1'b0, 1'b1);
    send_sample(16'd1, 1'b0, 1'b0);
    drain_results();

    // Final settings; now and then dead zones wide enough to leave no working span
    if ($urandom_range(0, 9) == 0) begin
      low_dz  = 16'($urandom_range(4000, 5000));
      high_dz = 16'($urandom_range(4000, 5000));
    end else begin
      low_dz  = 16'($urandom_range(0, 2500));
      high_dz = 16'($urandom_range(0, 2500));
    end
    hyst_w   = 16'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 5000)
                                                : $urandom_range(0, 300));
    span_min = 16'($urandom_range(0, 25000));
    write_settings(low_dz, high_dz, hyst_w, span_min);

    // Calibrate, with some broken passes mixed in
    while (tracker.ph != PH_READY)
      run_calibration($urandom_range(0, 2) != 0);

    // Ready phase: extremes, dead-zone edges, hysteresis edges, random
    while (n_sent < SAMPLES) begin
      kind = $urandom_range(0, 9);
      off  = $urandom_range(0, 4);
      off  = off - 2;
      case (kind)
        0: rd = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        1: rd = reading_near(int'(tracker.low_end), off);
        2: rd = reading_near(int'(tracker.high_end), off);
        3, 4, 5: begin
          off = int'(tracker.hyst_step) + off;
          if ($urandom_range(0, 1) != 0) off = -off;
          rd = reading_near(int'(tracker.held_rd), off);
        end
        default: rd = 16'($urandom);
      endcase
      send_sample(rd, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("run: %0d samples (%0d in ready phase), %0d words checked, %0d both-closed errors",
             n_sent, tracker.n_ready, tracker.n_checked, tracker.n_both);
    $display("run: %0d closes (%0d span errors), dead zones %0d/%0d, hysteresis %0d, floor %0d",
             tracker.n_attempts, tracker.n_span, tracker.low_dz, tracker.high_dz,
             tracker.hyst_w, tracker.min_span);
    if (tracker.n_fail == 0)
      $display("tb_lever_calibrate_and_scale passed");
    else
      $display("tb_lever_calibrate_and_scale failed");
    $finish;
  end

endmodule
